[design/tevq_pkg.sv]
// ----------------------------------------------------------------------------
// tevq_pkg
// Shared types and constants for the timer event queue.
// ----------------------------------------------------------------------------
package tevq_pkg;

    localparam int NUM_ENTRIES_DEFAULT = 16;
    localparam int MAX_RESULTS         = 16;
    localparam logic [15:0] LATE_LIMIT_RESET = 16'd5;

    // Request kinds carried on the slave-side tuser.
    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_ONESHOT  = 2'd1;
    localparam logic [1:0] REQ_PERIODIC = 2'd2;
    localparam logic [1:0] REQ_DEADLINE = 2'd3;

    // Result kinds carried on the master-side tuser.
    localparam logic [1:0] EVT_FIRED    = 2'd0;
    localparam logic [1:0] EVT_ACCEPTED = 2'd1;
    localparam logic [1:0] EVT_REJECTED = 2'd2;

    // One row of the entry memory.
    typedef struct packed {
        logic [31:0] fire_time;
        logic [15:0] period;
        logic [31:0] deadline;
        logic        has_deadline;
        logic [7:0]  callback;
        logic [15:0] order;
    } entry_t;

endpackage

[design/timer_event_queue.sv]
// ----------------------------------------------------------------------------
// timer_event_queue
// Bounded table of software timers, fired earliest first on each tick.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  -------   ---------  ------------------------------------------------------
//  s_*       in         tuser: req_type; tdata: callback_id, time_value, period_ms
//  m_*       out        tuser: event_kind; tdata: fired_id, late_flag,
//                       pending_count; tlast: last_result
//  cfg_*     in         late_limit, written whenever cfg_we is high
//
// A registration's answer waits in the holding register and, once the master
// side is free, reaches the output register as the slave side becomes ready
// again. A tick handles its due entries, fired or dropped, one at a time:
// every selection is one full scan of the single-port entry memory followed
// by handling the chosen entry, and a tick that reaches the result cap skips
// its final scan. Reset clears the time, the order counter, the valid bits
// and the pending result; memory rows are only read once written. A result
// waits in a holding register until the next one is known, so that its last
// flag is right; a stalled master side holds the block before each further
// firing.
//
module timer_event_queue #(
    parameter int NUM_ENTRIES = tevq_pkg::NUM_ENTRIES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // callback_id[7:0], time_value[39:8], period_ms[55:40]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // fired_id[7:0], late_flag[8], pending_count[13:9], zero
    output logic [1:0]  m_tuser,   // event_kind[1:0]
    output logic        m_tlast,   // last_result
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CW = $clog2(NUM_ENTRIES + 1);
    localparam int RW = $clog2(tevq_pkg::MAX_RESULTS + 1);
    localparam logic [IW:0] LAST_ISSUE = (IW + 1)'(NUM_ENTRIES);
    localparam logic [CW-1:0] FULL_COUNT = CW'(NUM_ENTRIES);
    localparam logic [RW-1:0] RESULT_CAP = RW'(tevq_pkg::MAX_RESULTS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIRE,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // Entry memory: one write port, one registered read port.
    tevq_pkg::entry_t mem [NUM_ENTRIES];
    tevq_pkg::entry_t rd_data_reg;

    logic [31:0]            now_reg;
    logic [15:0]            order_reg;
    logic [15:0]            late_limit_reg;
    logic [CW-1:0]          count_reg;
    logic [NUM_ENTRIES-1:0] valid_reg;
    logic [NUM_ENTRIES-1:0] done_reg;
    logic [RW-1:0]          nres_reg;
    logic [IW:0]            issue_reg;
    logic                   rdv_reg;
    logic [IW-1:0]          rdi_reg;
    logic                   best_found_reg;
    logic [IW-1:0]          best_idx_reg;
    tevq_pkg::entry_t       best_reg;

    // Holding register for the most recent result.
    logic       hold_valid_reg;
    logic [1:0] hold_kind_reg;
    logic [7:0] hold_id_reg;
    logic       hold_late_reg;
    logic [4:0] hold_cnt_reg;

    // Output register.
    logic       m_tvalid_reg;
    logic [1:0] m_kind_reg;
    logic [7:0] m_id_reg;
    logic       m_late_reg;
    logic [4:0] m_cnt_reg;
    logic       m_last_reg;

    // Input fields.
    logic [1:0]  req_type;
    logic [7:0]  callback_id;
    logic [31:0] time_value;
    logic [15:0] period_ms;

    assign req_type    = s_tuser;
    assign callback_id = s_tdata[7:0];
    assign time_value  = s_tdata[39:8];
    assign period_ms   = s_tdata[55:40];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {2'b00, m_cnt_reg, m_late_reg, m_id_reg};

    function automatic logic [4:0] low5(input logic [CW-1:0] c);
        logic [CW+4:0] ext;
        ext = {5'b00000, c};
        return ext[4:0];
    endfunction

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;

    // Lowest free slot for a registration.
    logic [IW-1:0] free_slot;
    always_comb
    begin
        free_slot = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = IW'(i);
            end
        end
    end

    logic is_full;
    assign is_full = (count_reg == FULL_COUNT);

    // Scan: one row read per cycle, its candidate compared in the cycle after the read.
    logic        issue_go;
    logic        scan_end;
    logic        cand;
    logic        better;
    logic [15:0] age_c;
    logic [15:0] age_b;

    assign issue_go = (state_reg == ST_SCAN) && (issue_reg < LAST_ISSUE);
    assign scan_end = (state_reg == ST_SCAN) && !issue_go && !rdv_reg;
    assign age_c    = order_reg - rd_data_reg.order;
    assign age_b    = order_reg - best_reg.order;
    assign cand     = rdv_reg && valid_reg[rdi_reg] && !done_reg[rdi_reg]
                      && (rd_data_reg.fire_time <= now_reg);
    assign better   = !best_found_reg
                      || (rd_data_reg.fire_time < best_reg.fire_time)
                      || ((rd_data_reg.fire_time == best_reg.fire_time) && (age_c > age_b));

    // Handling of the selected entry.
    logic        out_free;
    logic        fire_ok;
    logic        drop;
    logic        rearm;
    logic        late;
    logic [31:0] lateness;
    logic [32:0] rearm_sum;
    logic [31:0] rearm_time;
    logic        out_load;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign fire_ok    = !hold_valid_reg || out_free;
    assign drop       = best_reg.has_deadline && !(now_reg < best_reg.deadline);
    assign rearm      = (best_reg.period != 16'd0);
    assign lateness   = now_reg - best_reg.fire_time;
    assign late       = (lateness > {16'd0, late_limit_reg});
    assign rearm_sum  = {1'b0, now_reg} + {17'd0, best_reg.period};
    assign rearm_time = rearm_sum[32] ? 32'hFFFF_FFFF : rearm_sum[31:0];

    // The held result moves to the output register when a further firing
    // replaces it, or when the item is finished.
    assign out_load = ((state_reg == ST_FIRE) && !drop && fire_ok && hold_valid_reg)
                      || ((state_reg == ST_FINISH) && hold_valid_reg && out_free);

    // Memory write port.
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    tevq_pkg::entry_t mem_wdata;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = free_slot;
        mem_wdata = best_reg;
        if (state_reg == ST_IDLE)
        begin
            mem_we                 = s_fire && (req_type != tevq_pkg::REQ_TICK) && !is_full;
            mem_wdata.callback     = callback_id;
            mem_wdata.fire_time    = (req_type == tevq_pkg::REQ_ONESHOT) ? time_value : now_reg;
            mem_wdata.period       = (req_type == tevq_pkg::REQ_ONESHOT) ? 16'd0 : period_ms;
            mem_wdata.has_deadline = (req_type == tevq_pkg::REQ_DEADLINE);
            mem_wdata.deadline     = (req_type == tevq_pkg::REQ_DEADLINE) ? time_value : 32'd0;
            mem_wdata.order        = order_reg;
        end
        else if (state_reg == ST_FIRE)
        begin
            mem_we              = !drop && rearm && fire_ok;
            mem_waddr           = best_idx_reg;
            mem_wdata.fire_time = rearm_time;
            mem_wdata.order     = order_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[issue_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            order_reg      <= '0;
            late_limit_reg <= tevq_pkg::LATE_LIMIT_RESET;
            count_reg      <= '0;
            valid_reg      <= '0;
            done_reg       <= '0;
            nres_reg       <= '0;
            issue_reg      <= '0;
            rdv_reg        <= 1'b0;
            rdi_reg        <= '0;
            best_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            hold_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                late_limit_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        if (req_type == tevq_pkg::REQ_TICK)
                        begin
                            if (now_reg != 32'hFFFF_FFFF)
                            begin
                                now_reg <= now_reg + 32'd1;
                            end
                            done_reg       <= '0;
                            nres_reg       <= '0;
                            issue_reg      <= '0;
                            rdv_reg        <= 1'b0;
                            best_found_reg <= 1'b0;
                            state_reg      <= ST_SCAN;
                        end
                        else
                        begin
                            hold_valid_reg <= 1'b1;
                            hold_id_reg    <= callback_id;
                            hold_late_reg  <= 1'b0;
                            if (is_full)
                            begin
                                hold_kind_reg <= tevq_pkg::EVT_REJECTED;
                                hold_cnt_reg  <= low5(count_reg);
                            end
                            else
                            begin
                                hold_kind_reg        <= tevq_pkg::EVT_ACCEPTED;
                                hold_cnt_reg         <= low5(count_reg + CW'(1));
                                count_reg            <= count_reg + CW'(1);
                                valid_reg[free_slot] <= 1'b1;
                                order_reg            <= order_reg + 16'd1;
                            end
                            state_reg <= ST_FINISH;
                        end
                    end
                end

                ST_SCAN:
                begin
                    rdv_reg <= issue_go;
                    rdi_reg <= issue_reg[IW-1:0];
                    if (issue_go)
                    begin
                        issue_reg <= issue_reg + (IW + 1)'(1);
                    end
                    if (cand && better)
                    begin
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= rdi_reg;
                        best_reg       <= rd_data_reg;
                    end
                    if (scan_end)
                    begin
                        state_reg <= best_found_reg ? ST_FIRE : ST_FINISH;
                    end
                end

                ST_FIRE:
                begin
                    if (drop || fire_ok)
                    begin
                        // Either way the entry is finished for this tick; rescan.
                        done_reg[best_idx_reg] <= 1'b1;
                        issue_reg              <= '0;
                        rdv_reg                <= 1'b0;
                        best_found_reg         <= 1'b0;
                        if (drop)
                        begin
                            valid_reg[best_idx_reg] <= 1'b0;
                            count_reg               <= count_reg - CW'(1);
                            state_reg               <= ST_SCAN;
                        end
                        else
                        begin
                            if (hold_valid_reg)
                            begin
                                m_kind_reg   <= hold_kind_reg;
                                m_id_reg     <= hold_id_reg;
                                m_late_reg   <= hold_late_reg;
                                m_cnt_reg    <= hold_cnt_reg;
                                m_last_reg   <= 1'b0;
                            end
                            hold_valid_reg <= 1'b1;
                            hold_kind_reg  <= tevq_pkg::EVT_FIRED;
                            hold_id_reg    <= best_reg.callback;
                            hold_late_reg  <= late;
                            if (rearm)
                            begin
                                order_reg    <= order_reg + 16'd1;
                                hold_cnt_reg <= low5(count_reg);
                            end
                            else
                            begin
                                valid_reg[best_idx_reg] <= 1'b0;
                                count_reg               <= count_reg - CW'(1);
                                hold_cnt_reg            <= low5(count_reg - CW'(1));
                            end
                            nres_reg  <= nres_reg + RW'(1);
                            state_reg <= (nres_reg + RW'(1) == RESULT_CAP) ? ST_FINISH
                                                                           : ST_SCAN;
                        end
                    end
                end

                ST_FINISH:
                begin
                    if (!hold_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        m_kind_reg     <= hold_kind_reg;
                        m_id_reg       <= hold_id_reg;
                        m_late_reg     <= hold_late_reg;
                        m_cnt_reg      <= hold_cnt_reg;
                        m_last_reg     <= 1'b1;
                        hold_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timer event queue: a directed table, then
// random phases of registrations and ticks, each checked against a predictor.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = tevq_pkg::NUM_ENTRIES_DEFAULT;
    localparam int SETTLE       = 700;       // cycles to let a silent tick finish
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int EXP_DEPTH    = 1024;
    localparam int ROW_DEPTH    = 32;

    // One result as it appears on the master side.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] id;
        logic       late;
        logic [4:0] pending;
        logic       last;
    } timer_result_t;

    // One row of the directed table. Rows with has_typed set carry the
    // registration answer written out by hand.
    typedef struct {
        logic [1:0]    req;
        logic [7:0]    cb;
        logic [31:0]   tv;
        logic [15:0]   per;
        bit            has_typed;
        timer_result_t typed;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // callback_id[7:0], time_value[39:8], period_ms[55:40]
    logic [1:0]  s_tuser;   // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // fired_id[7:0], late_flag[8], pending_count[13:9], zero
    logic [1:0]  m_tuser;   // event_kind[1:0]
    logic        m_tlast;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    timer_event_queue i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the timer table.
    // ------------------------------------------------------------------
    logic [31:0] now_ms;
    logic [15:0] seq_counter;
    logic [15:0] late_limit;
    bit          slot_used [SLOTS];
    logic [31:0] slot_fire [SLOTS];
    logic [15:0] slot_period [SLOTS];
    logic [31:0] slot_deadline [SLOTS];
    bit          slot_has_deadline [SLOTS];
    logic [7:0]  slot_cb [SLOTS];
    logic [15:0] slot_seq [SLOTS];

    // Expected results, kept in a ring in arrival order.
    timer_result_t expected_ring [EXP_DEPTH];
    int            exp_head;
    int            exp_tail;
    int            errors;
    int            cycles;
    bit            sender_idles;
    bit            receiver_idles;

    function automatic int expect_count();
        return exp_tail - exp_head;
    endfunction

    function automatic void expect_put(timer_result_t r);
        expected_ring[exp_tail % EXP_DEPTH] = r;
        exp_tail++;
    endfunction

    function automatic timer_result_t expect_take();
        timer_result_t r;
        r = expected_ring[exp_head % EXP_DEPTH];
        exp_head++;
        return r;
    endfunction

    function automatic void expect_mark_last();
        timer_result_t r;
        r = expected_ring[(exp_tail - 1) % EXP_DEPTH];
        r.last = 1'b1;
        expected_ring[(exp_tail - 1) % EXP_DEPTH] = r;
    endfunction

    function automatic void expect_overwrite_last(timer_result_t r);
        expected_ring[(exp_tail - 1) % EXP_DEPTH] = r;
    endfunction

    function automatic logic [4:0] used_slots();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i])
                n++;
        return n[4:0];
    endfunction

    // Earlier fire time wins; on a tie the older sequence number wins, age
    // being measured back from the current counter so that wrap is harmless.
    function automatic bit fires_first(int a, int b);
        logic [15:0] age_a;
        logic [15:0] age_b;
        if (slot_fire[a] != slot_fire[b])
            return slot_fire[a] < slot_fire[b];
        age_a = seq_counter - slot_seq[a];
        age_b = seq_counter - slot_seq[b];
        return age_a > age_b;
    endfunction

    function automatic void queue_result(logic [1:0] kind, logic [7:0] id, logic late);
        timer_result_t r;
        r.kind    = kind;
        r.id      = id;
        r.late    = late;
        r.pending = used_slots();
        r.last    = 1'b0;
        expect_put(r);
    endfunction

    // Works out every result that one accepted request causes.
    function automatic void predict_request(logic [1:0] req, logic [7:0] cb,
                                            logic [31:0] tv, logic [15:0] per);
        int          free_slot;
        int          best;
        int          fired;
        bit          handled [SLOTS];
        logic [32:0] rearm;
        timer_result_t r;
        free_slot = -1;
        fired     = 0;
        if (req != tevq_pkg::REQ_TICK)
        begin
            for (int i = SLOTS - 1; i >= 0; i--)
                if (!slot_used[i])
                    free_slot = i;
            if (free_slot < 0)
                queue_result(tevq_pkg::EVT_REJECTED, cb, 1'b0);
            else
            begin
                slot_used[free_slot]         = 1'b1;
                slot_cb[free_slot]           = cb;
                slot_fire[free_slot]         = (req == tevq_pkg::REQ_ONESHOT) ? tv : now_ms;
                slot_period[free_slot]       = (req == tevq_pkg::REQ_ONESHOT) ? 16'd0 : per;
                slot_has_deadline[free_slot] = (req == tevq_pkg::REQ_DEADLINE);
                slot_deadline[free_slot]     = (req == tevq_pkg::REQ_DEADLINE) ? tv : 32'd0;
                slot_seq[free_slot]          = seq_counter;
                seq_counter++;
                queue_result(tevq_pkg::EVT_ACCEPTED, cb, 1'b0);
            end
            expect_mark_last();
            return;
        end

        if (now_ms != 32'hFFFF_FFFF)
            now_ms++;
        for (int i = 0; i < SLOTS; i++)
            handled[i] = 1'b0;
        while (fired < tevq_pkg::MAX_RESULTS)
        begin
            best = -1;
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i] && !handled[i] && slot_fire[i] <= now_ms)
                    if (best < 0 || fires_first(i, best))
                        best = i;
            if (best < 0)
                break;
            handled[best] = 1'b1;
            // An entry whose deadline has been reached leaves silently.
            if (slot_has_deadline[best] && !(now_ms < slot_deadline[best]))
            begin
                slot_used[best] = 1'b0;
                continue;
            end
            r.late = (now_ms - slot_fire[best]) > {16'd0, late_limit};
            if (slot_period[best] != 16'd0)
            begin
                rearm = {1'b0, now_ms} + {17'd0, slot_period[best]};
                slot_fire[best] = rearm[32] ? 32'hFFFF_FFFF : rearm[31:0];
                slot_seq[best]  = seq_counter;
                seq_counter++;
            end
            else
                slot_used[best] = 1'b0;
            queue_result(tevq_pkg::EVT_FIRED, slot_cb[best], r.late);
            fired++;
        end
        if (fired > 0)
            expect_mark_last();
    endfunction

    // ------------------------------------------------------------------
    // Checking of the master side.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        timer_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expect_count() == 0)
                report_mismatch("result with none outstanding", {16'd0, m_tdata}, 32'd0);
            else
            begin
                want = expect_take();
                if (m_tuser != want.kind)
                    report_mismatch("event_kind", 32'(m_tuser), 32'(want.kind));
                if (m_tdata[7:0] != want.id)
                    report_mismatch("fired_id", 32'(m_tdata[7:0]), 32'(want.id));
                if (m_tdata[8] != want.late)
                    report_mismatch("late_flag", 32'(m_tdata[8]), 32'(want.late));
                if (m_tdata[13:9] != want.pending)
                    report_mismatch("pending_count", 32'(m_tdata[13:9]), 32'(want.pending));
                if (m_tlast != want.last)
                    report_mismatch("last_result", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // The receiver stalls about 23 percent of the time while stalls are on.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= !(receiver_idles && $urandom_range(99) < 23);
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timer_event_queue: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Drives one request at the falling edge and holds it until the
    // transfer, predicting its results at the accepting edge. Returns at the
    // rising edge of the transfer, so that the next request can go out at
    // the following falling edge without dropping tvalid.
    task automatic send_request(logic [1:0] req, logic [7:0] cb, logic [31:0] tv,
                                logic [15:0] per, bit has_typed = 1'b0,
                                timer_result_t typed = '0);
        @(negedge clk);
        while (sender_idles && $urandom_range(99) < 23)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = req;
        s_tdata  = {per, tv, cb};
        do
            @(posedge clk);
        while (!s_tready);
        predict_request(req, cb, tv, per);
        if (has_typed)
            expect_overwrite_last(typed);
    endtask

    // Waits until every expected result has been taken, then lets a silent
    // tick run out before anything touches the configuration.
    task automatic drain_and_settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (expect_count() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_late_limit(logic [15:0] value);
        drain_and_settle();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        late_limit = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // A random request. Most time values land close to the current time so
    // that entries become due, fire, re-arm and hit their deadlines; now and
    // then a value is fully random to exercise every bit.
    task automatic send_random_request(int tick_pct);
        logic [1:0]  req;
        logic [31:0] tv;
        logic [15:0] per;
        if ($urandom_range(99) < tick_pct)
            req = tevq_pkg::REQ_TICK;
        else
            req = 2'($urandom_range(3, 1));
        if ($urandom_range(9) == 0)
            tv = $urandom;
        else if ($urandom_range(5) == 0 && now_ms > 10)
            tv = now_ms - $urandom_range(10);      // already in the past
        else
            tv = now_ms + $urandom_range(25);
        if ($urandom_range(9) == 0)
            per = 16'($urandom_range(16'hFFFF));
        else
            per = 16'($urandom_range(6));
        send_request(req, 8'($urandom_range(255)), tv, per);
    endtask

    // ------------------------------------------------------------------
    // Directed table, walked from reset with late_limit at its reset value.
    // ------------------------------------------------------------------
    function automatic stim_row_t row(logic [1:0] req, logic [7:0] cb, logic [31:0] tv,
                                      logic [15:0] per, bit has_typed = 1'b0,
                                      logic [1:0] kind = tevq_pkg::EVT_ACCEPTED,
                                      logic [4:0] pending = 5'd0);
        stim_row_t r;
        r.req       = req;
        r.cb        = cb;
        r.tv        = tv;
        r.per       = per;
        r.has_typed = has_typed;
        r.typed     = '{kind: kind, id: cb, late: 1'b0, pending: pending, last: 1'b1};
        return r;
    endfunction

    stim_row_t directed [ROW_DEPTH];
    int        n_directed;

    function automatic void add_row(stim_row_t r);
        directed[n_directed] = r;
        n_directed++;
    endfunction

    initial
    begin
        errors         = 0;
        cycles         = 0;
        exp_head       = 0;
        exp_tail       = 0;
        n_directed     = 0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = tevq_pkg::REQ_TICK;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        now_ms      = '0;
        seq_counter = '0;
        late_limit  = tevq_pkg::LATE_LIMIT_RESET;
        for (int i = 0; i < SLOTS; i++)
            slot_used[i] = 1'b0;

        // A tick on an empty table yields nothing. The first registrations
        // after reset take the lowest slots, so their answers are plain.
        add_row(row(tevq_pkg::REQ_TICK,     8'h00, 32'h0,         16'h0));
        add_row(row(tevq_pkg::REQ_ONESHOT,  8'h00, 32'h0,         16'hFFFF, 1,
                    tevq_pkg::EVT_ACCEPTED, 1));
        add_row(row(tevq_pkg::REQ_PERIODIC, 8'hFF, 32'hFFFF_FFFF, 16'h0, 1,
                    tevq_pkg::EVT_ACCEPTED, 2));
        add_row(row(tevq_pkg::REQ_DEADLINE, 8'hAA, 32'd3,         16'd1, 1,
                    tevq_pkg::EVT_ACCEPTED, 3));
        add_row(row(tevq_pkg::REQ_ONESHOT,  8'h55, 32'hFFFF_FFFF, 16'h0, 1,
                    tevq_pkg::EVT_ACCEPTED, 4));
        // Three entries due at once: fired in registration order.
        add_row(row(tevq_pkg::REQ_TICK,     8'h00, 32'h0,         16'h0));
        add_row(row(tevq_pkg::REQ_TICK,     8'h00, 32'h0,         16'h0));
        // By this tick the deadline entry has reached its deadline and left silently.
        add_row(row(tevq_pkg::REQ_TICK,     8'h00, 32'h0,         16'h0));
        // A long period, a one-shot in the past, and two periodic entries
        // on the same time so that re-arming follows waiting entries.
        add_row(row(tevq_pkg::REQ_PERIODIC, 8'h01, 32'h0,         16'hFFFF));
        add_row(row(tevq_pkg::REQ_ONESHOT,  8'h02, 32'd1,         16'h1234));
        add_row(row(tevq_pkg::REQ_PERIODIC, 8'h03, 32'h0,         16'd1));
        add_row(row(tevq_pkg::REQ_ONESHOT,  8'h04, 32'd4,         16'h0));
        add_row(row(tevq_pkg::REQ_TICK,     8'h00, 32'h0,         16'h0));
        add_row(row(tevq_pkg::REQ_TICK,     8'h00, 32'h0,         16'h0));
        // A one-shot well in the past fires late.
        add_row(row(tevq_pkg::REQ_ONESHOT,  8'h80, 32'h0,         16'h0));
        add_row(row(tevq_pkg::REQ_DEADLINE, 8'h7F, 32'h0,         16'd2));
        add_row(row(tevq_pkg::REQ_TICK,     8'h00, 32'h0,         16'h0));
        add_row(row(tevq_pkg::REQ_TICK,     8'h00, 32'h0,         16'h0));

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < n_directed; i++)
            send_request(directed[i].req, directed[i].cb, directed[i].tv, directed[i].per,
                         directed[i].has_typed, directed[i].typed);
        // Push the time further on with more ticks.
        repeat (8) send_request(tevq_pkg::REQ_TICK, 8'h00, 32'h0, 16'h0);

        // A tight late limit makes nearly every delayed firing late.
        write_late_limit(16'd0);
        repeat (60) send_random_request(45);

        // Fill the table past its size: the extra registrations are
        // rejected, then the new entries fall due together on one tick.
        drain_and_settle();
        for (int i = 0; i < SLOTS + 3; i++)
            send_request(tevq_pkg::REQ_ONESHOT, 8'hC0 + i[7:0], now_ms + 32'd1, 16'h0);
        send_request(tevq_pkg::REQ_TICK, 8'h00, 32'h0, 16'h0);
        repeat (20) send_random_request(30);

        // The widest late limit: only firings far behind their time are late.
        write_late_limit(16'hFFFF);
        repeat (100) send_random_request(45);

        // A stretch with neither side idling.
        write_late_limit(16'($urandom_range(16'hFFFF)));
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        repeat (100) send_random_request(50);
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;

        // Back to a small limit, with long periodic runs.
        write_late_limit(16'd3);
        repeat (130) send_random_request(55);

        drain_and_settle();
        if (errors == 0)
            $display("timer_event_queue: match");
        else
            $display("timer_event_queue: mismatch");
        $finish;
    end

endmodule

[files.f]
design/tevq_pkg.sv
design/timer_event_queue.sv
test/tb_top.sv
